// ----- hdl/byte_stuffing_escaper_defines.svh -----
// Assertion macros shared by the byte stuffing escaper RTL
`ifndef BYTE_STUFFING_ESCAPER_DEFINES_SVH
`define BYTE_STUFFING_ESCAPER_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset
`define BSE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset
`define BSE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/bse_pkg.sv -----
// Types and constants of the byte stuffing escaper
`timescale 1ns / 1ps

package bse_pkg;

  localparam int unsigned MAX_FRAME = 4096;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned LEN_W     = 13;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 13;
  localparam int unsigned RES_DEPTH = 3;
  localparam int unsigned RES_CNT_W = 2;

  localparam logic [LEN_W-1:0] MAX_FRAME_LEN = LEN_W'(MAX_FRAME);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FLAG_VALUE   = 2'd0,
    CFG_ESCAPE_VALUE = 2'd1,
    CFG_XOR_MASK     = 2'd2,
    CFG_CAPACITY     = 2'd3
  } cfg_reg_e;

  localparam logic [BYTE_W-1:0] RST_FLAG_VALUE   = 8'd126;
  localparam logic [BYTE_W-1:0] RST_ESCAPE_VALUE = 8'd125;
  localparam logic [BYTE_W-1:0] RST_XOR_MASK     = 8'd32;
  localparam logic [LEN_W-1:0]  RST_CAPACITY     = 13'd4096;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              is_data;
    logic [LEN_W-1:0]  frame_length;
    logic              overflowed;
    logic              run_last;
  } result_t;

endpackage

// ----- hdl/byte_stuffing_escaper.sv -----
// Byte stuffing escaper top level: escape, capacity check and result queue
`timescale 1ns / 1ps
`include "byte_stuffing_escaper_defines.svh"

// Channel  | Direction | Handshake              | Payload
// ---------+-----------+------------------------+------------------------------------------
// input    | in        | in_valid_i / in_stall_o | data_byte_i, frame_last_i
// output   | out       | out_valid_o/out_stall_i | out_byte_o, is_data_o, frame_length_o,
//          |           |                        | overflowed_o, run_last_o
// config   | in        | cfg_we_i               | cfg_index_i, cfg_data_i
//
// Each request is escaped and checked against capacity in the cycle it is
// accepted; its results, up to three, go into a three-entry result queue.
// The queue feeds an output register that issues one result per cycle while
// the output is not stalled. A plain byte gives one result, an escape pair or
// a plain last byte two, and an escaped last byte three; a dropped byte that
// is not the last gives nothing, and a dropped last byte gives only status.
// A new request is taken once the queue is empty or its final entry moves
// to the output register in that cycle; output stalls hold the register.
// Reset clears the frame count, the overflow state, the queue and the
// output register and loads the register defaults.

module byte_stuffing_escaper (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [bse_pkg::BYTE_W-1:0]    data_byte_i,
  input  logic                          frame_last_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [bse_pkg::BYTE_W-1:0]    out_byte_o,
  output logic                          is_data_o,
  output logic [bse_pkg::LEN_W-1:0]     frame_length_o,
  output logic                          overflowed_o,
  output logic                          run_last_o,
  input  logic                          cfg_we_i,
  input  logic [bse_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [bse_pkg::CFG_DAT_W-1:0] cfg_data_i
);

  import bse_pkg::*;

  // Configuration registers
  logic [BYTE_W-1:0] flag_value_q;
  logic [BYTE_W-1:0] escape_value_q;
  logic [BYTE_W-1:0] xor_mask_q;
  logic [LEN_W-1:0]  capacity_q;

  // Frame state
  logic [LEN_W-1:0] out_count_q, out_count_d;
  logic             dropping_q, dropping_d;

  // Result queue, head at entry 0
  result_t              queue_q [RES_DEPTH];
  logic [RES_CNT_W-1:0] queue_cnt_q;

  // Output register
  result_t out_q;
  logic    out_valid_q;

  logic in_acc;
  logic pop;
  logic queue_free;

  // Request decode
  logic [LEN_W-1:0]     cap;
  logic [LEN_W-1:0]     room;
  logic                 needs_esc;
  logic [1:0]           n_data;
  logic [RES_CNT_W-1:0] n_total;
  result_t              data0, data1, status;
  result_t              load [RES_DEPTH];

  // Move the queue head out whenever the output register is free or drains
  assign pop        = (queue_cnt_q != '0) && (!out_valid_q || !out_stall_i);
  assign queue_free = (queue_cnt_q == '0) || ((queue_cnt_q == RES_CNT_W'(1)) && pop);
  assign in_stall_o = !queue_free;
  assign in_acc     = in_valid_i && queue_free;

  always_comb begin
    cap       = (capacity_q > MAX_FRAME_LEN) ? MAX_FRAME_LEN : capacity_q;
    room      = (out_count_q < cap) ? (cap - out_count_q) : '0;
    needs_esc = (data_byte_i == flag_value_q) || (data_byte_i == escape_value_q);

    out_count_d = out_count_q;
    dropping_d  = dropping_q;
    n_data      = 2'd0;

    if (!dropping_q) begin
      if (needs_esc) begin
        if (room < LEN_W'(2)) begin
          dropping_d = 1'b1;
        end else begin
          n_data      = 2'd2;
          out_count_d = out_count_q + LEN_W'(2);
        end
      end else if (room != '0) begin
        n_data      = 2'd1;
        out_count_d = out_count_q + LEN_W'(1);
      end else begin
        dropping_d = 1'b1;
      end
    end

    data0 = '{out_byte: needs_esc ? escape_value_q : data_byte_i, is_data: 1'b1,
              frame_length: '0, overflowed: 1'b0, run_last: 1'b0};
    data1 = '{out_byte: data_byte_i ^ xor_mask_q, is_data: 1'b1,
              frame_length: '0, overflowed: 1'b0, run_last: 1'b0};
    status = '{out_byte: '0, is_data: 1'b0, frame_length: out_count_d,
               overflowed: dropping_d, run_last: 1'b0};

    n_total = RES_CNT_W'(n_data) + RES_CNT_W'(frame_last_i);

    // Status lands straight after the data results
    load[0] = (n_data != 2'd0) ? data0 : status;
    load[1] = (n_data == 2'd2) ? data1 : status;
    load[2] = status;
    for (int i = 0; i < RES_DEPTH; i++) begin
      load[i].run_last = (RES_CNT_W'(i) == (n_total - RES_CNT_W'(1)));
    end

    // End of frame: restart the count after the status result
    if (frame_last_i) begin
      out_count_d = '0;
      dropping_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flag_value_q   <= RST_FLAG_VALUE;
      escape_value_q <= RST_ESCAPE_VALUE;
      xor_mask_q     <= RST_XOR_MASK;
      capacity_q     <= RST_CAPACITY;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        CFG_FLAG_VALUE:   flag_value_q   <= cfg_data_i[BYTE_W-1:0];
        CFG_ESCAPE_VALUE: escape_value_q <= cfg_data_i[BYTE_W-1:0];
        CFG_XOR_MASK:     xor_mask_q     <= cfg_data_i[BYTE_W-1:0];
        CFG_CAPACITY:     capacity_q     <= cfg_data_i[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Frame state advances only on an accepted request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_count_q <= '0;
      dropping_q  <= 1'b0;
    end else if (in_acc) begin
      out_count_q <= out_count_d;
      dropping_q  <= dropping_d;
    end
  end

  // Queue count: load replaces whatever is left, else drop the popped head
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      queue_cnt_q <= '0;
    end else if (in_acc) begin
      queue_cnt_q <= n_total;
    end else if (pop) begin
      queue_cnt_q <= queue_cnt_q - RES_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      for (int i = 0; i < RES_DEPTH; i++) begin
        queue_q[i] <= load[i];
      end
    end else if (pop) begin
      for (int i = 0; i < RES_DEPTH - 1; i++) begin
        queue_q[i] <= queue_q[i+1];
      end
    end
  end

  // Output register: hold while stalled, refill from the queue head
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pop) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      out_q <= queue_q[0];
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_byte_o     = out_q.out_byte;
  assign is_data_o      = out_q.is_data;
  assign frame_length_o = out_q.frame_length;
  assign overflowed_o   = out_q.overflowed;
  assign run_last_o     = out_q.run_last;

  // Checks
  `BSE_ASSERT_IMP(a_count_bound, 1'b1, out_count_q <= MAX_FRAME_LEN, "frame count beyond limit")
  `BSE_ASSERT_NXT(a_frame_restart, in_acc && frame_last_i, (out_count_q == '0) && !dropping_q, "frame state not cleared after last byte")
  `BSE_ASSERT_IMP(a_status_last, out_valid_o && !is_data_o, run_last_o, "status result without run_last")
  `BSE_ASSERT_IMP(a_data_clean, out_valid_o && is_data_o, (frame_length_o == '0) && !overflowed_o, "data result carries status fields")

endmodule

// ----- tb/testbench.sv -----
// Testbench for the byte stuffing escaper: directed and random frames against a scoreboard
`timescale 1ns / 1ps

module testbench;
  import bse_pkg::*;

  // One request as queued for the driver: the byte, its end-of-frame mark and
  // the number of idle cycles to insert before it is offered.
  typedef struct {
    logic [BYTE_W-1:0] value;
    logic              last;
    int unsigned       gap;
  } frame_byte_t;

  logic                 clk_i        = 1'b0;
  logic                 rst_ni       = 1'b0;
  logic                 in_valid_i   = 1'b0;
  logic                 in_stall_o;
  logic [BYTE_W-1:0]    data_byte_i  = '0;
  logic                 frame_last_i = 1'b0;
  logic                 out_valid_o;
  logic                 out_stall_i  = 1'b0;
  logic [BYTE_W-1:0]    out_byte_o;
  logic                 is_data_o;
  logic [LEN_W-1:0]     frame_length_o;
  logic                 overflowed_o;
  logic                 run_last_o;
  logic                 cfg_we_i     = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index_i  = '0;
  logic [CFG_DAT_W-1:0] cfg_data_i   = '0;

  // Register shadows and frame state of the predictor
  logic [BYTE_W-1:0] flag_reg  = RST_FLAG_VALUE;
  logic [BYTE_W-1:0] esc_reg   = RST_ESCAPE_VALUE;
  logic [BYTE_W-1:0] mask_reg  = RST_XOR_MASK;
  logic [LEN_W-1:0]  cap_reg   = RST_CAPACITY;
  logic [LEN_W-1:0]  frame_count    = '0;
  logic              frame_dropping = 1'b0;

  frame_byte_t frame_bytes_q[$];      // requests still to be offered
  result_t     stuffed_results_q[$];  // results predicted but not yet seen

  frame_byte_t next_byte;
  logic        staged   = 1'b0;   // next_byte has been taken from the queue
  logic        in_taken = 1'b0;   // the request on the input was accepted
  logic        calm     = 1'b0;   // no idle cycles on either side
  logic        hold_req = 1'b0;   // ask the receiver for a long hold-off
  int unsigned hold_left = 0;
  int unsigned rx_wait   = 0;
  int unsigned mismatches = 0;

  byte_stuffing_escaper dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .data_byte_i    (data_byte_i),
    .frame_last_i   (frame_last_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_byte_o     (out_byte_o),
    .is_data_o      (is_data_o),
    .frame_length_o (frame_length_o),
    .overflowed_o   (overflowed_o),
    .run_last_o     (run_last_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  always #6 clk_i = ~clk_i;

  // Work out the results of one accepted request and append them to the
  // scoreboard. Escape when the byte matches the flag or the escape value,
  // count every byte sent against the capacity (never above MAX_FRAME), and
  // drop the rest of the frame once a byte does not fit. The last byte adds
  // a status result and clears the frame state.
  function automatic void stuff_byte(input logic [BYTE_W-1:0] b, input logic last);
    result_t     res[3];
    int unsigned n;
    int unsigned limit;
    int unsigned room;
    n     = 0;
    limit = (cap_reg < MAX_FRAME) ? cap_reg : MAX_FRAME;
    room  = (frame_count < limit) ? limit - frame_count : 0;
    if (!frame_dropping) begin
      if (b == flag_reg || b == esc_reg) begin
        if (room < 2) begin
          frame_dropping = 1'b1;
        end else begin
          res[n++] = {esc_reg, 1'b1, LEN_W'(0), 1'b0, 1'b0};
          res[n++] = {b ^ mask_reg, 1'b1, LEN_W'(0), 1'b0, 1'b0};
          frame_count = frame_count + LEN_W'(2);
        end
      end else if (room > 0) begin
        res[n++] = {b, 1'b1, LEN_W'(0), 1'b0, 1'b0};
        frame_count = frame_count + LEN_W'(1);
      end else begin
        frame_dropping = 1'b1;
      end
    end
    if (last) begin
      res[n++] = {BYTE_W'(0), 1'b0, frame_count, frame_dropping, 1'b0};
      frame_count    = '0;
      frame_dropping = 1'b0;
    end
    if (n > 0) res[n-1].run_last = 1'b1;
    for (int unsigned i = 0; i < n; i++) stuffed_results_q.push_back(res[i]);
  endfunction

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // Sample both handshakes at the rising edge: check each result taken from
  // the output against the oldest prediction, then predict for each request
  // taken on the input.
  always @(posedge clk_i) begin : scoreboard
    result_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (stuffed_results_q.size() == 0) begin
          $error("result with nothing predicted: out_byte %0d is_data %0d length %0d",
                 out_byte_o, is_data_o, frame_length_o);
          mismatches++;
        end else begin
          want = stuffed_results_q.pop_front();
          check_field("out_byte", want.out_byte, out_byte_o);
          check_field("is_data", want.is_data, is_data_o);
          check_field("frame_length", want.frame_length, frame_length_o);
          check_field("overflowed", want.overflowed, overflowed_o);
          check_field("run_last", want.run_last, run_last_o);
        end
        rx_wait = calm ? 0 : $urandom_range(0, 4);
      end
      if (in_valid_i && !in_stall_o) begin
        stuff_byte(data_byte_i, frame_last_i);
        in_taken = 1'b1;
      end
    end
  end

  // Driver: hold a stalled request, otherwise count down the gap of the next
  // queued request and offer it. Valid stays high across back-to-back
  // requests without being lowered in between.
  always @(negedge clk_i) begin
    if (rst_ni && !(in_valid_i && !in_taken)) begin
      in_taken = 1'b0;
      if (!staged && frame_bytes_q.size() != 0) begin
        next_byte = frame_bytes_q.pop_front();
        staged    = 1'b1;
      end
      if (staged && next_byte.gap == 0) begin
        in_valid_i   <= 1'b1;
        data_byte_i  <= next_byte.value;
        frame_last_i <= next_byte.last;
        staged        = 1'b0;
      end else begin
        in_valid_i <= 1'b0;
        if (staged) next_byte.gap--;
      end
    end
  end

  // Receiver: stall after each result for its drawn count, and for a long
  // stretch when asked, so the block fills up and stalls its input.
  always @(negedge clk_i) begin
    if (hold_req) begin
      hold_left = 60;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else if (rx_wait > 0) begin
      rx_wait--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  task automatic queue_byte(input logic [BYTE_W-1:0] value, input logic last);
    frame_byte_t fb;
    fb.value = value;
    fb.last  = last;
    fb.gap   = calm ? 0 : $urandom_range(0, 4);
    frame_bytes_q.push_back(fb);
  endtask

  // Queue a well-formed frame, weighted towards bytes that need escaping
  task automatic queue_frame(input int unsigned len);
    logic [BYTE_W-1:0] value;
    for (int unsigned i = 0; i < len; i++) begin
      case ($urandom_range(0, 9))
        0, 1, 2: value = flag_reg;
        3, 4:    value = esc_reg;
        default: value = BYTE_W'($urandom);
      endcase
      queue_byte(value, i == len - 1);
    end
  endtask

  // Write one register and update the shadow; only called while idle
  task automatic write_reg(input cfg_reg_e idx, input logic [CFG_DAT_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_FLAG_VALUE:   flag_reg = val[BYTE_W-1:0];
      CFG_ESCAPE_VALUE: esc_reg  = val[BYTE_W-1:0];
      CFG_XOR_MASK:     mask_reg = val[BYTE_W-1:0];
      CFG_CAPACITY:     cap_reg  = val[LEN_W-1:0];
      default: ;
    endcase
  endtask

  // Wait until every request is taken and every result seen, then allow for
  // a trailing dropped byte that gives no result.
  task automatic settle();
    while (frame_bytes_q.size() != 0 || staged || in_valid_i ||
           stuffed_results_q.size() != 0)
      @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  initial begin
    int unsigned target;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Default registers: plain extremes, both escaped values, escaped and
    // plain last bytes, single-byte frames
    queue_byte(8'h00, 1'b0);
    queue_byte(8'hFF, 1'b0);
    queue_byte(RST_FLAG_VALUE, 1'b0);
    queue_byte(RST_ESCAPE_VALUE, 1'b0);
    queue_byte(8'h55, 1'b1);
    queue_byte(RST_FLAG_VALUE, 1'b1);
    queue_byte(RST_ESCAPE_VALUE, 1'b1);
    queue_byte(8'hA5, 1'b1);
    settle();

    // Zero capacity: overflow on the first byte, drop the rest of the frame
    write_reg(CFG_CAPACITY, '0);
    queue_byte(8'h11, 1'b0);
    queue_byte(RST_FLAG_VALUE, 1'b1);
    settle();

    // Capacity of three: a plain byte, then a pair that fits
    // exactly before a plain byte is dropped
    write_reg(CFG_CAPACITY, 13'd3);
    queue_byte(8'h01, 1'b0);
    queue_byte(RST_FLAG_VALUE, 1'b0);
    queue_byte(8'h02, 1'b0);
    queue_byte(8'h03, 1'b1);
    queue_byte(RST_ESCAPE_VALUE, 1'b0);
    queue_byte(8'h04, 1'b0);
    queue_byte(8'h05, 1'b0);
    queue_byte(8'h06, 1'b1);
    settle();

    // Capacity of two: escape pair with a single byte of room
    write_reg(CFG_CAPACITY, 13'd2);
    queue_byte(8'h09, 1'b0);
    queue_byte(RST_FLAG_VALUE, 1'b0);
    queue_byte(8'h0A, 1'b1);
    settle();

    // Register extremes; capacity above MAX_FRAME
    write_reg(CFG_FLAG_VALUE, '0);
    write_reg(CFG_ESCAPE_VALUE, 13'h0FF);
    write_reg(CFG_XOR_MASK, 13'h0FF);
    write_reg(CFG_CAPACITY, 13'h1FFF);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'h7E, 1'b1);
    settle();

    // One frame of escape pairs fills the capacity exactly; the plain last
    // byte then finds no room and the length reads back as the full count
    write_reg(CFG_CAPACITY, 13'd64);
    calm = 1'b1;
    for (int unsigned i = 0; i < 32; i++) queue_byte(8'h00, 1'b0);
    queue_byte(8'h42, 1'b1);
    settle();

    // Random phases: new settings each time, frames of random length
    for (int unsigned p = 0; p < 6; p++) begin
      calm = (p == 3);
      write_reg(CFG_FLAG_VALUE, (p == 4) ? 13'h0FF : CFG_DAT_W'($urandom_range(0, 8191)));
      if (p == 2)
        write_reg(CFG_ESCAPE_VALUE, {5'd0, flag_reg});
      else if (p == 4)
        write_reg(CFG_ESCAPE_VALUE, '0);
      else
        write_reg(CFG_ESCAPE_VALUE, CFG_DAT_W'($urandom_range(0, 8191)));
      write_reg(CFG_XOR_MASK, (p == 0) ? '0 : CFG_DAT_W'($urandom_range(0, 8191)));
      case (p)
        0:       write_reg(CFG_CAPACITY, 13'd1);
        3:       write_reg(CFG_CAPACITY, LEN_W'(MAX_FRAME));
        5:       write_reg(CFG_CAPACITY, CFG_DAT_W'($urandom_range(0, 8191)));
        default: write_reg(CFG_CAPACITY, CFG_DAT_W'($urandom_range(3, 24)));
      endcase
      target = 56;
      while (frame_bytes_q.size() < target) queue_frame($urandom_range(1, 12));
      if (p == 1) begin
        repeat (5) @(posedge clk_i);
        hold_req = 1'b1;
      end
      settle();
    end

    if (mismatches == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Watchdog: far beyond the slowest correct run
  initial begin
    #20_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
